FILE: rtl/sdmf_pkg.sv
// Shared types, constants and helpers for the sorted diagonal matrix fill block.
// No dependencies; used by every module under rtl/.
`default_nettype none

package sdmf_pkg;

    localparam int MAX_DIM = 8;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int VAL_W   = 32;
    localparam int DIM_W   = 4;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DIAG_W  = $clog2(2 * MAX_DIM - 1);
    localparam int CFG_W   = 2;

    typedef enum logic [CFG_W-1:0] {
        CFG_ROW_COUNT   = 2'd0,
        CFG_COL_COUNT   = 2'd1,
        CFG_ZIGZAG_MODE = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // per-cycle command for every cell of the chain
    typedef struct packed {
        logic load;   // insert the broadcast request value
        logic shift;  // move every value one cell toward the head
    } t_cell_ctl;

    // zero counts as one, anything above the limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] res;
        res = d;
        if (d == '0) begin
            res = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sdmf_cell.sv
// One cell of the insertion chain: holds one sorted value.
// Depends on sdmf_pkg.
`default_nettype none

module sdmf_cell (
    input  wire logic                               i_clk,
    input  wire sdmf_pkg::t_cell_ctl                i_ctl,
    input  wire logic signed [sdmf_pkg::VAL_W-1:0]  i_new_value,
    input  wire logic                               i_occupied,
    input  wire logic                               i_at_end,
    input  wire logic signed [sdmf_pkg::VAL_W-1:0]  i_left_value,
    input  wire logic                               i_left_greater,
    input  wire logic signed [sdmf_pkg::VAL_W-1:0]  i_right_value,
    output logic signed [sdmf_pkg::VAL_W-1:0]       o_value,
    output logic                                    o_greater
);

    logic signed [sdmf_pkg::VAL_W-1:0] r_value;
    logic signed [sdmf_pkg::VAL_W-1:0] n_value;

    // strictly greater keeps equal values in arrival order
    assign o_greater = i_occupied && (r_value > i_new_value);
    assign o_value   = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.shift) begin
            n_value = i_right_value;
        end else if (i_ctl.load) begin
            if (i_left_greater) begin
                n_value = i_left_value;
            end else if (o_greater || i_at_end) begin
                n_value = i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

FILE: rtl/sdmf_walk.sv
// Destination walker: steps row and column along the anti-diagonals.
// Depends on sdmf_pkg.
`default_nettype none

module sdmf_walk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_step,
    input  wire logic [sdmf_pkg::DIM_W-1:0]    i_rows,
    input  wire logic [sdmf_pkg::DIM_W-1:0]    i_cols,
    input  wire logic                          i_zigzag,
    output logic [sdmf_pkg::POS_W-1:0]         o_row,
    output logic [sdmf_pkg::POS_W-1:0]         o_col
);

    logic [sdmf_pkg::DIAG_W-1:0] r_diag;
    logic [sdmf_pkg::DIAG_W-1:0] n_diag;
    logic [sdmf_pkg::POS_W-1:0]  r_row;
    logic [sdmf_pkg::POS_W-1:0]  n_row;
    logic [sdmf_pkg::DIAG_W-1:0] w_next_diag;
    logic                        w_rev;
    logic                        w_next_rev;
    logic                        w_diag_end;

    function automatic logic [sdmf_pkg::POS_W-1:0] diag_lo(
        input logic [sdmf_pkg::DIAG_W-1:0] d,
        input logic [sdmf_pkg::DIM_W-1:0]  cols
    );
        logic [sdmf_pkg::DIAG_W-1:0] t;
        t = '0;
        if (d >= sdmf_pkg::DIAG_W'(cols)) begin
            t = d - sdmf_pkg::DIAG_W'(cols) + sdmf_pkg::DIAG_W'(1);
        end
        return t[sdmf_pkg::POS_W-1:0];
    endfunction

    function automatic logic [sdmf_pkg::POS_W-1:0] diag_hi(
        input logic [sdmf_pkg::DIAG_W-1:0] d,
        input logic [sdmf_pkg::DIM_W-1:0]  rows
    );
        logic [sdmf_pkg::DIAG_W-1:0] t;
        t = d;
        if (d >= sdmf_pkg::DIAG_W'(rows)) begin
            t = sdmf_pkg::DIAG_W'(rows) - sdmf_pkg::DIAG_W'(1);
        end
        return t[sdmf_pkg::POS_W-1:0];
    endfunction

    function automatic logic [sdmf_pkg::POS_W-1:0] POS_W_cut(
        input logic [sdmf_pkg::DIAG_W-1:0] x
    );
        return x[sdmf_pkg::POS_W-1:0];
    endfunction

    assign w_next_diag = r_diag + sdmf_pkg::DIAG_W'(1);
    assign w_rev       = i_zigzag && r_diag[0];
    assign w_next_rev  = i_zigzag && w_next_diag[0];
    assign w_diag_end  = w_rev ? (r_row == diag_lo(r_diag, i_cols))
                               : (r_row == diag_hi(r_diag, i_rows));

    always_comb begin
        n_diag = r_diag;
        n_row  = r_row;
        if (i_start) begin
            n_diag = '0;
            n_row  = '0;
        end else if (i_step) begin
            if (w_diag_end) begin
                n_diag = w_next_diag;
                n_row  = w_next_rev ? diag_hi(w_next_diag, i_rows)
                                    : diag_lo(w_next_diag, i_cols);
            end else begin
                n_row = w_rev ? r_row - sdmf_pkg::POS_W'(1)
                              : r_row + sdmf_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag <= '0;
            r_row  <= '0;
        end else begin
            r_diag <= n_diag;
            r_row  <= n_row;
        end
    end

    assign o_row = r_row;
    assign o_col = POS_W_cut(r_diag - sdmf_pkg::DIAG_W'(r_row));

endmodule

`default_nettype wire

FILE: rtl/sorted_diagonal_matrix_fill_unit.sv
// Top level of the sorted diagonal matrix fill block.
// Depends on sdmf_pkg, sdmf_cell and sdmf_walk.
//
// Usage
//   Input channel (i_valid / o_stall / i_element_value): one matrix element
//   per request, row-major. A request is taken at a clock edge with i_valid
//   high and o_stall low. Each taken element is inserted into a chain of 64
//   cells that keeps all loaded values ascending. When the element count
//   reaches rows*cols, the block raises o_stall and emits the burst: one
//   result per cycle while the output is not stalled, on the output channel
//   (o_valid / i_stall / o_dest_row / o_dest_col / o_placed_value /
//   o_final_flag), smallest value first, destinations walking the
//   anti-diagonals. After the last element is taken, the state register
//   moves to emit and the first result is then loaded into the output
//   register; each result shifts the cell chain one value toward its head.
//   A stall on the output holds the output register and freezes the burst;
//   the next matrix may start loading while the final result still waits.
//   Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready; write it only while the block is idle.
//   Reset clears the element count, the state and the output valid, and
//   loads rows 8, cols 8, zigzag on. Cell contents are not cleared.
`default_nettype none

module sorted_diagonal_matrix_fill_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // element requests
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [sdmf_pkg::VAL_W-1:0]   i_element_value,
    // placement results
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [sdmf_pkg::POS_W-1:0]               o_dest_row,
    output logic [sdmf_pkg::POS_W-1:0]               o_dest_col,
    output logic signed [sdmf_pkg::VAL_W-1:0]        o_placed_value,
    output logic                                     o_final_flag,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sdmf_pkg::CFG_W-1:0]          i_cfg_index,
    input  wire logic [sdmf_pkg::DIM_W-1:0]          i_cfg_data
);

    localparam int DEPTH = sdmf_pkg::DEPTH;
    localparam int CNT_W = sdmf_pkg::CNT_W;
    localparam int VAL_W = sdmf_pkg::VAL_W;
    localparam int DIM_W = sdmf_pkg::DIM_W;
    localparam int POS_W = sdmf_pkg::POS_W;

    // configuration registers
    logic [DIM_W-1:0] r_row_count;
    logic [DIM_W-1:0] r_col_count;
    logic             r_zigzag;

    // control
    sdmf_pkg::t_state r_state;
    sdmf_pkg::t_state n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] n_left;

    // output register
    logic                    r_out_valid;
    logic [POS_W-1:0]        r_out_row;
    logic [POS_W-1:0]        r_out_col;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_final;

    logic [DIM_W-1:0] w_rows;
    logic [DIM_W-1:0] w_cols;
    logic [CNT_W-1:0] w_total;
    logic [CNT_W-1:0] w_eff_count;
    logic [CNT_W-1:0] w_count_inc;
    logic             w_in_take;
    logic             w_fire;
    logic             w_walk_start;
    logic [POS_W-1:0] w_walk_row;
    logic [POS_W-1:0] w_walk_col;

    sdmf_pkg::t_cell_ctl     w_ctl;
    logic signed [VAL_W-1:0] w_value   [DEPTH];
    logic                    w_greater [DEPTH];

    // configuration port: always ready, unknown indexes dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= DIM_W'(8);
            r_col_count <= DIM_W'(8);
            r_zigzag    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sdmf_pkg::CFG_ROW_COUNT:   r_row_count <= i_cfg_data;
                sdmf_pkg::CFG_COL_COUNT:   r_col_count <= i_cfg_data;
                sdmf_pkg::CFG_ZIGZAG_MODE: r_zigzag    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // matrix size; a count already at or past it means the matrix shrank,
    // so drop the partial load and start over
    assign w_rows      = sdmf_pkg::clamp_dim(r_row_count);
    assign w_cols      = sdmf_pkg::clamp_dim(r_col_count);
    assign w_total     = CNT_W'(w_rows) * CNT_W'(w_cols);
    assign w_eff_count = (r_count >= w_total) ? '0 : r_count;
    assign w_count_inc = w_eff_count + CNT_W'(1);

    // handshakes
    assign o_stall   = (r_state == sdmf_pkg::ST_EMIT);
    assign w_in_take = i_valid && !o_stall;
    assign w_fire    = (r_state == sdmf_pkg::ST_EMIT) && (!r_out_valid || !i_stall);

    // state machine: load elements, then emit the burst
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_left       = r_left;
        w_walk_start = 1'b0;
        w_ctl.load   = 1'b0;
        w_ctl.shift  = 1'b0;
        case (r_state)
            sdmf_pkg::ST_LOAD: begin
                if (w_in_take) begin
                    w_ctl.load   = 1'b1;
                    n_count      = w_count_inc;
                    if (w_count_inc == w_total) begin
                        n_state      = sdmf_pkg::ST_EMIT;
                        n_left       = w_total;
                        w_walk_start = 1'b1;
                    end
                end
            end
            sdmf_pkg::ST_EMIT: begin
                if (w_fire) begin
                    w_ctl.shift = 1'b1;
                    n_left      = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = sdmf_pkg::ST_LOAD;
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = sdmf_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdmf_pkg::ST_LOAD;
            r_count <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
        end
    end

    // insertion chain: each cell compares against the broadcast request
    // value and on insert takes its left neighbor or the new value, on shift its right
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CNT_W-1:0] K = CNT_W'(g);
        logic signed [VAL_W-1:0] w_left_value;
        logic                    w_left_greater;
        logic signed [VAL_W-1:0] w_right_value;

        if (g == 0) begin : g_head
            assign w_left_value   = '0;
            assign w_left_greater = 1'b0;
        end else begin : g_body
            assign w_left_value   = w_value[g-1];
            assign w_left_greater = w_greater[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_value = '0;
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
        end

        sdmf_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_new_value    (i_element_value),
            .i_occupied     (K < w_eff_count),
            .i_at_end       (K == w_eff_count),
            .i_left_value   (w_left_value),
            .i_left_greater (w_left_greater),
            .i_right_value  (w_right_value),
            .o_value        (w_value[g]),
            .o_greater      (w_greater[g])
        );
    end

    // destination for the value at the head of the chain
    sdmf_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_walk_start),
        .i_step   (w_fire),
        .i_rows   (w_rows),
        .i_cols   (w_cols),
        .i_zigzag (r_zigzag),
        .o_row    (w_walk_row),
        .o_col    (w_walk_col)
    );

    // output register: load on fire, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_row   <= w_walk_row;
            r_out_col   <= w_walk_col;
            r_out_value <= w_value[0];
            r_out_final <= (r_left == CNT_W'(1));
        end
    end

    assign o_valid        = r_out_valid;
    assign o_dest_row     = r_out_row;
    assign o_dest_col     = r_out_col;
    assign o_placed_value = r_out_value;
    assign o_final_flag   = r_out_final;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for sorted_diagonal_matrix_fill_unit: matrices go in as
// element requests and every placement is checked against an in-bench sorter.
// Depends on sdmf_pkg and the RTL under rtl/.

module tb_top;

    localparam int MAX_DIM = sdmf_pkg::MAX_DIM;
    localparam int DEPTH   = sdmf_pkg::DEPTH;
    localparam int VAL_W   = sdmf_pkg::VAL_W;
    localparam int DIM_W   = sdmf_pkg::DIM_W;
    localparam int POS_W   = sdmf_pkg::POS_W;
    localparam int CFG_W   = sdmf_pkg::CFG_W;

    // quiet cycles allowed before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    // cycles to let the block settle before touching its registers
    localparam int SETTLE_CYCLES  = 4;
    // register slot with no register behind it
    localparam logic [CFG_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_placement;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_valid         = 1'b0;
    logic signed [VAL_W-1:0] i_element_value = '0;
    logic                    i_stall         = 1'b0;
    logic                    i_cfg_valid     = 1'b0;
    logic [CFG_W-1:0]        i_cfg_index     = '0;
    logic [DIM_W-1:0]        i_cfg_data      = '0;

    logic                    o_stall;
    logic                    o_valid;
    logic [POS_W-1:0]        o_dest_row;
    logic [POS_W-1:0]        o_dest_col;
    logic signed [VAL_W-1:0] o_placed_value;
    logic                    o_final_flag;
    logic                    o_cfg_ready;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sorted_diagonal_matrix_fill_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_dest_row      (o_dest_row),
        .o_dest_col      (o_dest_col),
        .o_placed_value  (o_placed_value),
        .o_final_flag    (o_final_flag),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    int gap_pct   = 0;    // chance per cycle that the sender holds off
    int stall_pct = 0;    // chance per cycle that the receiver stalls

    int mismatch_count     = 0;
    int elements_sent      = 0;
    int placements_checked = 0;
    int cfg_writes         = 0;
    int matrices_completed = 0;

    // mirror of the block's registers, updated on each accepted write
    logic [DIM_W-1:0] row_reg    = 4'd8;
    logic [DIM_W-1:0] col_reg    = 4'd8;
    logic             zigzag_reg = 1'b1;

    // ascending copy of the current load and its fill level
    logic signed [VAL_W-1:0] sort_buf [DEPTH];
    int                      fill_count = 0;

    // placements still owed by the block, oldest first
    t_placement pending_placements [$];

    // ------------------------------------------------------------------
    // Sorter and diagonal walker
    // ------------------------------------------------------------------
    // Zero rows or columns behave as one; anything past the array size
    // behaves as the array size.
    function automatic int eff_dim(input logic [DIM_W-1:0] d);
        return (d == '0) ? 1 : ((int'(d) > MAX_DIM) ? MAX_DIM : int'(d));
    endfunction

    // Insert one accepted element; when it completes the matrix, queue the
    // whole sorted burst along the anti-diagonals.
    function automatic void insert_element(input logic signed [VAL_W-1:0] v);
        int rows;
        int cols;
        int total;
        int pos;
        int k;
        int r;
        int c;
        t_placement p;
        rows  = eff_dim(row_reg);
        cols  = eff_dim(col_reg);
        total = rows * cols;

        // a load already past the current size is abandoned
        if (fill_count >= total) fill_count = 0;

        // stable insertion: equal values stay in arrival order
        pos = fill_count;
        while (pos > 0 && sort_buf[pos-1] > v) begin
            sort_buf[pos] = sort_buf[pos-1];
            pos--;
        end
        sort_buf[pos] = v;
        fill_count++;
        if (fill_count < total) return;

        k = 0;
        for (int s = 0; s <= rows + cols - 2; s++) begin
            for (int t = 0; t < rows; t++) begin
                // odd diagonals run bottom to top in zigzag mode
                r = (zigzag_reg && (s % 2 == 1)) ? rows - 1 - t : t;
                c = s - r;
                if (r <= s && c < cols) begin
                    p.row   = POS_W'(r);
                    p.col   = POS_W'(c);
                    p.value = sort_buf[k];
                    p.last  = (k + 1 == total);
                    pending_placements = {pending_placements, p};
                    k++;
                end
            end
        end
        fill_count = 0;
        matrices_completed++;
    endfunction

    // ------------------------------------------------------------------
    // Request and register drivers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Send one element; valid stays high afterwards so back-to-back requests
    // need no second assignment in the same step.
    task automatic send_element(input logic signed [VAL_W-1:0] v);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_element_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        insert_element(v);
        elements_sent++;
    endtask

    // Write one register; hold keeps valid up for a following write.
    task automatic write_register(input logic [CFG_W-1:0] idx,
                                  input logic [DIM_W-1:0] data,
                                  input bit hold);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            sdmf_pkg::CFG_ROW_COUNT:   row_reg    = data;
            sdmf_pkg::CFG_COL_COUNT:   col_reg    = data;
            sdmf_pkg::CFG_ZIGZAG_MODE: zigzag_reg = data[0];
            default: ;  // unmapped slot: nothing changes
        endcase
        cfg_writes++;
        if (!hold) i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [DIM_W-1:0] rows,
                             input logic [DIM_W-1:0] cols,
                             input logic [DIM_W-1:0] zig_data);
        write_register(sdmf_pkg::CFG_ROW_COUNT, rows, 1'b1);
        write_register(sdmf_pkg::CFG_COL_COUNT, cols, 1'b1);
        write_register(sdmf_pkg::CFG_ZIGZAG_MODE, zig_data, 1'b0);
    endtask

    // Drop valid, wait out every owed placement, then let the block settle
    // so a register write finds it idle.
    task automatic finish_requests();
        i_valid <= 1'b0;
        while (pending_placements.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mix of extremes, a narrow band that forces duplicates, and full-range
    // patterns so every bit toggles.
    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(5))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return VAL_W'(int'($urandom_range(6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    // Mostly small sides, sometimes zero, now and then large (5 to 15, past the array size above 8).
    function automatic logic [DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return '0;
        if (roll == 1) return DIM_W'($urandom_range(5, 15));
        return DIM_W'($urandom_range(1, 4));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall, and check every accepted placement
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_placements.size() == 0) begin
                report_mismatch($sformatf("placement (%0d,%0d)=%0d with none owed",
                                          o_dest_row, o_dest_col, o_placed_value));
            end else begin
                want = pending_placements.pop_front();
                if (o_dest_row !== want.row)
                    report_mismatch($sformatf("dest_row %0d, want %0d",
                                              o_dest_row, want.row));
                if (o_dest_col !== want.col)
                    report_mismatch($sformatf("dest_col %0d, want %0d",
                                              o_dest_col, want.col));
                if (o_placed_value !== want.value)
                    report_mismatch($sformatf("placed_value %0d, want %0d at (%0d,%0d)",
                                              o_placed_value, want.value,
                                              want.row, want.col));
                if (o_final_flag !== want.last)
                    report_mismatch($sformatf("final_flag %0b, want %0b at (%0d,%0d)",
                                              o_final_flag, want.last,
                                              want.row, want.col));
            end
            placements_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any accepted request, placement or write counts as progress
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d placements owed",
                     quiet_cycles, pending_placements.size());
            $display("sorted_diagonal_matrix_fill_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Full 8x8 zigzag matrix straight out of reset, no register written.
    task automatic test_reset_defaults();
        repeat (DEPTH) send_element(rand_value());
        finish_requests();
    endtask

    // Both sides written as zero act as 1x1: every request is a whole matrix.
    task automatic test_single_cell();
        configure(4'd0, 4'd0, 4'd0);
        send_element(VAL_MIN);
        send_element(VAL_MAX);
        send_element('0);
        finish_requests();
    endtask

    // Column count of 15 clamps to 8; zigzag data with all bits set.
    // Duplicates and extremes land in one row.
    task automatic test_single_row_clamped();
        configure(4'd1, 4'd15, 4'b1111);
        send_element(VAL_MAX);
        send_element(-32'sd1);
        send_element('0);
        send_element(VAL_MIN);
        send_element(32'sd5);
        send_element(32'sd5);
        send_element(-32'sd1);
        send_element(32'sd1);
        finish_requests();
    endtask

    // Plain order on a 2x2 (zigzag data has only upper bits set), then a
    // write to the spare slot, which must leave every register alone.
    task automatic test_plain_order_spare_index();
        write_register(sdmf_pkg::CFG_ROW_COUNT, 4'd2, 1'b1);
        write_register(sdmf_pkg::CFG_COL_COUNT, 4'd2, 1'b1);
        write_register(sdmf_pkg::CFG_ZIGZAG_MODE, 4'b1110, 1'b1);
        write_register(CFG_SPARE_IDX, 4'b0001, 1'b0);
        send_element(32'sd3);
        send_element(-32'sd3);
        send_element(32'sd3);
        send_element('0);
        finish_requests();
    endtask

    // Shrink the matrix below the part already loaded: the partial load is
    // dropped and the next request starts a fresh matrix.
    task automatic test_shrink_during_load();
        configure(4'd3, 4'd2, 4'd1);
        repeat (4) send_element(rand_value());
        finish_requests();
        configure(4'd2, 4'd1, 4'd0);
        repeat (2) send_element(rand_value());
        finish_requests();
    endtask

    // Random shapes and modes. Most runs are whole matrices, some stop part
    // way so the next shape either continues or abandons them, and some
    // follow the previous matrix without a pause or a new register setting.
    task automatic test_random_matrices(input int budget);
        int  sent;
        int  total;
        int  n;
        bit  keep_cfg;
        sent = 0;
        while (sent < budget) begin
            keep_cfg = (sent > 0) && ($urandom_range(2) == 0);
            if (!keep_cfg) begin
                finish_requests();
                configure(pick_dim(), pick_dim(), DIM_W'($urandom_range(15)));
            end
            total = eff_dim(row_reg) * eff_dim(col_reg);
            n = ($urandom_range(5) == 0) ? $urandom_range(1, total) : total;
            repeat (n) send_element(rand_value());
            sent += n;
        end
        finish_requests();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // light sender gaps, heavy receiver stalls
        gap_pct   = 8;
        stall_pct = 68;
        test_reset_defaults();
        test_single_cell();
        test_single_row_clamped();
        test_plain_order_spare_index();
        test_shrink_during_load();
        test_random_matrices(20);

        // heavy sender gaps, light receiver stalls
        gap_pct   = 68;
        stall_pct = 8;
        test_random_matrices(20);

        // full rate both ways
        gap_pct   = 0;
        stall_pct = 0;
        test_random_matrices(20);

        $display("run: %0d elements in, %0d matrices completed, %0d placements checked",
                 elements_sent, matrices_completed, placements_checked);
        $display("run: %0d register writes, %0d mismatches",
                 cfg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("sorted_diagonal_matrix_fill_unit regression: pass");
        end else begin
            $display("sorted_diagonal_matrix_fill_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/sdmf_pkg.sv
rtl/sdmf_cell.sv
rtl/sdmf_walk.sv
rtl/sorted_diagonal_matrix_fill_unit.sv
tb/tb_top.sv
